// ===== design/lstt_pkg.sv =====
// Shared types, constants and handshake structs for the slot table.
package lstt_pkg;

  localparam int SLOTS       = 256;
  localparam int KEY_BITS    = 32;
  localparam int HANDLE_BITS = 16;

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int LIMIT_W = 9;
  localparam int CMP_W   = ((CNT_W > LIMIT_W) ? CNT_W : LIMIT_W) + 1;
  localparam int CMD_W   = 2;
  localparam int RES_W   = 2;
  localparam int MARK_W  = 2;
  localparam int ENTRY_W = MARK_W + KEY_BITS + HANDLE_BITS;

  localparam int IN_FIELDS_W  = 2 * KEY_BITS + 2 * HANDLE_BITS;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = SLOT_W + HANDLE_BITS + CNT_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-3:0] REG_LIMIT = '0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(120);

  localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
  localparam logic [MARK_W-1:0] MARK_LIVE  = 2'd1;
  localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_STORE   = 2'd0,
    CMD_REMOVE  = 2'd1,
    CMD_FIND    = 2'd2,
    CMD_REPLACE = 2'd3
  } cmd_t;

  typedef enum logic [RES_W-1:0] {
    RES_DONE      = 2'd0,
    RES_NOT_FOUND = 2'd1,
    RES_FULL      = 2'd2,
    RES_RESERVED  = 2'd3
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic req_load;
    logic commit;
    logic set_full;
    logic set_rsv;
    logic rewind;
    logic cpt_move;
    logic clr_step;
    logic cpt_done;
    logic out_load;
  } lstt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full_refuse;
    logic rsv_refuse;
    logic hit;
    logic miss_end;
    logic miss_full;
    logic cpt_req;
    logic ev_last;
    logic w_end;
    logic out_free;
  } lstt_stat_t;

endpackage

// ===== design/linear_slot_table_with_tombstones.sv =====
// Top level of the slot table of keyed handles with tombstone deletion.
// The block takes one transaction at a time. A transaction passes through accept,
// check, a scan of the slots and result load: a store stops at the first free
// slot, a remove or replace at its match or the first empty slot, and a find at
// its match or after all 256 slots. The scan rate is set by the single read port
// of the slot RAM, one slot per cycle. A remove that pushes the tombstone count
// above the limit adds a compaction that moves every live entry to the front
// and then clears the valid bits of the slots behind the last live
// entry. Reset clears the whole table at once through per-slot valid bits, so
// no clearing pass is needed. The result waits in an output register, and the
// next transaction is taken while it is still unclaimed. The tombstone limit
// lives at byte address 0 of the APB port and must be written while idle.
module linear_slot_table_with_tombstones (
  input  logic                            clk,
  input  logic                            rst_n,
  // in_tdata: key, handle, new_key, new_handle (from bit 0 up)
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lstt_pkg::IN_DATA_W-1:0]  in_tdata,
  // in_tuser: cmd
  input  logic [lstt_pkg::CMD_W-1:0]      in_tuser,
  // out_tdata: slot, found_handle, live_count, zero pad (from bit 0 up)
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lstt_pkg::OUT_DATA_W-1:0] out_tdata,
  // out_tuser: status
  output logic [lstt_pkg::RES_W-1:0]      out_tuser,
  // APB configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lstt_pkg::APB_AW-1:0]     paddr,
  input  logic [lstt_pkg::APB_DW-1:0]     pwdata,
  output logic [lstt_pkg::APB_DW-1:0]     prdata,
  output logic                            pready
);

  logic [lstt_pkg::LIMIT_W-1:0] limit_r;
  logic                         limit_sel;
  lstt_pkg::lstt_cmd_t          cmd;
  lstt_pkg::lstt_stat_t         stat;

  // Register decode: word index taken from the address above the byte lanes
  assign pready    = 1'b1;
  assign limit_sel = (paddr[lstt_pkg::APB_AW-1:2] == lstt_pkg::REG_LIMIT);
  assign prdata    = limit_sel ? lstt_pkg::APB_DW'(limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= lstt_pkg::LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && limit_sel) begin
      limit_r <= pwdata[lstt_pkg::LIMIT_W-1:0];
    end
  end

  // Sequence each transaction through check, scan and optional compaction
  lstt_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid_i (in_tvalid),
    .in_tready_o (in_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Hold the table, counters and result register
  lstt_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .req_cmd_i    (in_tuser),
    .req_data_i   (in_tdata),
    .limit_i      (limit_r),
    .out_tvalid_o (out_tvalid),
    .out_tready_i (out_tready),
    .out_tdata_o  (out_tdata),
    .out_tuser_o  (out_tuser)
  );

endmodule

// ===== design/lstt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lstt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_r <= mem[raddr_i];
  end

  assign rdata_o = rdata_r;

endmodule

// ===== design/lstt_ctrl.sv =====
// Controller state machine: sequences check, scan, compaction and response.
module lstt_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid_i,
  output logic                 in_tready_o,
  input  lstt_pkg::lstt_stat_t stat_i,
  output lstt_pkg::lstt_cmd_t  cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_CHECK   = 7'b0000010,
    S_SCAN    = 7'b0000100,
    S_CPRIME  = 7'b0001000,
    S_COMPACT = 7'b0010000,
    S_CLEAR   = 7'b0100000,
    S_RESP    = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt   = state_r;
    in_tready_o = 1'b0;
    cmd_o       = '0;
    case (state_r)
      S_IDLE: begin
        in_tready_o = 1'b1;
        if (in_tvalid_i) begin
          cmd_o.req_load = 1'b1;
          state_nxt      = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.full_refuse) begin
          cmd_o.set_full = 1'b1;
          state_nxt      = S_RESP;
        end else if (stat_i.rsv_refuse) begin
          cmd_o.set_rsv = 1'b1;
          state_nxt     = S_RESP;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.hit) begin
          cmd_o.commit = 1'b1;
          if (stat_i.cpt_req) begin
            cmd_o.rewind = 1'b1;
            state_nxt    = S_CPRIME;
          end else begin
            state_nxt = S_RESP;
          end
        end else if (stat_i.miss_end) begin
          cmd_o.set_full = stat_i.miss_full;
          state_nxt      = S_RESP;
        end
      end
      S_CPRIME: begin
        state_nxt = S_COMPACT;
      end
      S_COMPACT: begin
        cmd_o.cpt_move = 1'b1;
        if (stat_i.ev_last) begin
          state_nxt = S_CLEAR;
        end
      end
      S_CLEAR: begin
        if (stat_i.w_end) begin
          cmd_o.cpt_done = 1'b1;
          state_nxt      = S_RESP;
        end else begin
          cmd_o.clr_step = 1'b1;
        end
      end
      S_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/lstt_dp.sv =====
// Datapath: slot RAM, valid bits, counters, scan compare and result register.
module lstt_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  lstt_pkg::lstt_cmd_t              cmd_i,
  output lstt_pkg::lstt_stat_t             stat_o,
  input  logic [lstt_pkg::CMD_W-1:0]       req_cmd_i,
  input  logic [lstt_pkg::IN_DATA_W-1:0]   req_data_i,
  input  logic [lstt_pkg::LIMIT_W-1:0]     limit_i,
  output logic                             out_tvalid_o,
  input  logic                             out_tready_i,
  output logic [lstt_pkg::OUT_DATA_W-1:0]  out_tdata_o,
  output logic [lstt_pkg::RES_W-1:0]       out_tuser_o
);

  localparam int KB = lstt_pkg::KEY_BITS;
  localparam int HB = lstt_pkg::HANDLE_BITS;
  localparam int SW = lstt_pkg::SLOT_W;
  localparam int CW = lstt_pkg::CNT_W;

  // Request payload
  lstt_pkg::cmd_t op_r;
  logic [KB-1:0]  key_r;
  logic [HB-1:0]  handle_r;
  logic [KB-1:0]  nkey_r;
  logic [HB-1:0]  nhandle_r;

  // Scan pointers and counters
  logic [SW-1:0] rd_idx_r;
  logic [SW-1:0] ev_idx_r;
  logic [CW-1:0] w_r;
  logic [CW-1:0] live_r;
  logic [CW-1:0] tomb_r;

  logic [lstt_pkg::SLOTS-1:0] valid_r;
  logic                       rd_valid_r;

  lstt_pkg::res_t res_status_r;
  logic [SW-1:0]  res_slot_r;
  logic [HB-1:0]  res_found_r;

  logic           out_valid_r;
  lstt_pkg::res_t out_status_r;
  logic [SW-1:0]  out_slot_r;
  logic [HB-1:0]  out_found_r;
  logic [CW-1:0]  out_live_r;

  logic                        ram_we;
  logic [SW-1:0]               ram_waddr;
  logic [lstt_pkg::ENTRY_W-1:0] ram_wdata;
  logic [lstt_pkg::ENTRY_W-1:0] ram_rdata;

  logic          v_we;
  logic [SW-1:0] v_idx;
  logic          v_val;

  logic [lstt_pkg::MARK_W-1:0] ev_mark;
  logic [KB-1:0] rd_key;
  logic [HB-1:0] rd_handle;
  logic ev_live, ev_empty, ev_tomb, key_eq, hit, need_cpt;
  logic is_store, is_remove, is_find, is_replace;

  lstt_ram #(
    .WIDTH(lstt_pkg::ENTRY_W),
    .DEPTH(lstt_pkg::SLOTS)
  ) u_ram (
    .clk     (clk),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (rd_idx_r),
    .rdata_o (ram_rdata)
  );

  assign rd_key    = ram_rdata[HB +: KB];
  assign rd_handle = ram_rdata[HB-1:0];
  assign ev_mark   = rd_valid_r ? ram_rdata[lstt_pkg::ENTRY_W-1 -: lstt_pkg::MARK_W]
                                : lstt_pkg::MARK_EMPTY;
  assign ev_live   = (ev_mark == lstt_pkg::MARK_LIVE);
  assign ev_empty  = (ev_mark == lstt_pkg::MARK_EMPTY);
  assign ev_tomb   = (ev_mark == lstt_pkg::MARK_TOMB);
  assign key_eq    = (rd_key == key_r);

  assign is_store   = (op_r == lstt_pkg::CMD_STORE);
  assign is_remove  = (op_r == lstt_pkg::CMD_REMOVE);
  assign is_find    = (op_r == lstt_pkg::CMD_FIND);
  assign is_replace = (op_r == lstt_pkg::CMD_REPLACE);

  always_comb begin
    case (op_r)
      lstt_pkg::CMD_STORE:   hit = !ev_live;
      lstt_pkg::CMD_REMOVE:  hit = ev_live && key_eq;
      lstt_pkg::CMD_FIND:    hit = ev_live && ((key_r == '0) || key_eq);
      lstt_pkg::CMD_REPLACE: hit = ev_live && (rd_handle == handle_r);
      default:               hit = 1'b0;
    endcase
  end

  assign need_cpt = (lstt_pkg::CMP_W'(tomb_r) + lstt_pkg::CMP_W'(1))
                    > lstt_pkg::CMP_W'(limit_i);

  always_comb begin
    stat_o             = '0;
    stat_o.full_refuse = is_store && (live_r >= CW'(lstt_pkg::SLOTS));
    stat_o.rsv_refuse  = (is_store && (&key_r)) || (is_replace && (&nkey_r));
    stat_o.hit         = hit;
    stat_o.ev_last     = (ev_idx_r == SW'(lstt_pkg::SLOTS - 1));
    stat_o.miss_end    = ((is_remove || is_replace) && ev_empty) || stat_o.ev_last;
    stat_o.miss_full   = is_store;
    stat_o.cpt_req     = is_remove && need_cpt;
    stat_o.w_end       = (w_r == CW'(lstt_pkg::SLOTS));
    stat_o.out_free    = !out_valid_r || out_tready_i;
  end

  // RAM and valid-bit writes
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ev_idx_r;
    ram_wdata = {lstt_pkg::MARK_LIVE, key_r, handle_r};
    v_we      = 1'b0;
    v_idx     = ev_idx_r;
    v_val     = 1'b1;
    if (cmd_i.commit) begin
      case (op_r)
        lstt_pkg::CMD_STORE: begin
          ram_we = 1'b1;
          v_we   = 1'b1;
        end
        lstt_pkg::CMD_REMOVE: begin
          ram_we    = 1'b1;
          ram_wdata = {lstt_pkg::MARK_TOMB, rd_key, rd_handle};
        end
        lstt_pkg::CMD_REPLACE: begin
          ram_we    = 1'b1;
          ram_wdata = {lstt_pkg::MARK_LIVE, nkey_r, nhandle_r};
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end else if (cmd_i.cpt_move && ev_live) begin
      ram_we    = 1'b1;
      ram_waddr = w_r[SW-1:0];
      ram_wdata = {lstt_pkg::MARK_LIVE, rd_key, rd_handle};
      v_we      = 1'b1;
      v_idx     = w_r[SW-1:0];
    end else if (cmd_i.clr_step) begin
      v_we  = 1'b1;
      v_idx = w_r[SW-1:0];
      v_val = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.req_load) begin
      op_r      <= lstt_pkg::cmd_t'(req_cmd_i);
      key_r     <= req_data_i[KB-1:0];
      handle_r  <= req_data_i[KB +: HB];
      nkey_r    <= req_data_i[KB+HB +: KB];
      nhandle_r <= req_data_i[2*KB+HB +: HB];
    end
    ev_idx_r   <= rd_idx_r;
    rd_valid_r <= valid_r[rd_idx_r];
    if (cmd_i.req_load) begin
      res_status_r <= lstt_pkg::RES_NOT_FOUND;
      res_slot_r   <= '0;
      res_found_r  <= '0;
    end else if (cmd_i.set_full) begin
      res_status_r <= lstt_pkg::RES_FULL;
    end else if (cmd_i.set_rsv) begin
      res_status_r <= lstt_pkg::RES_RESERVED;
    end else if (cmd_i.commit) begin
      res_status_r <= lstt_pkg::RES_DONE;
      res_slot_r   <= ev_idx_r;
      res_found_r  <= is_find ? rd_handle : '0;
    end
    if (cmd_i.out_load) begin
      out_status_r <= res_status_r;
      out_slot_r   <= res_slot_r;
      out_found_r  <= res_found_r;
      out_live_r   <= live_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r    <= '0;
      w_r         <= '0;
      live_r      <= '0;
      tomb_r      <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd_i.req_load || cmd_i.rewind) begin
        rd_idx_r <= '0;
      end else begin
        rd_idx_r <= rd_idx_r + SW'(1);
      end
      if (cmd_i.rewind) begin
        w_r <= '0;
      end else if ((cmd_i.cpt_move && ev_live) || cmd_i.clr_step) begin
        w_r <= w_r + CW'(1);
      end
      if (cmd_i.commit && is_store) begin
        live_r <= live_r + CW'(1);
      end else if (cmd_i.commit && is_remove && (live_r != '0)) begin
        live_r <= live_r - CW'(1);
      end
      if (cmd_i.cpt_done) begin
        tomb_r <= '0;
      end else if (cmd_i.commit && is_remove) begin
        tomb_r <= tomb_r + CW'(1);
      end else if (cmd_i.commit && is_store && ev_tomb && (tomb_r != '0)) begin
        tomb_r <= tomb_r - CW'(1);
      end
      if (v_we) begin
        valid_r[v_idx] <= v_val;
      end
      if (cmd_i.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready_i) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid_o = out_valid_r;
  assign out_tdata_o  = {{lstt_pkg::OUT_PAD_W{1'b0}}, out_live_r, out_found_r, out_slot_r};
  assign out_tuser_o  = out_status_r;

endmodule

// ===== design/lstt_chk.sv =====
// Port-level checker for the slot table, attached to the top level by bind.
module lstt_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [lstt_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [lstt_pkg::RES_W-1:0]      out_tuser
);

  localparam int SW = lstt_pkg::SLOT_W;
  localparam int HB = lstt_pkg::HANDLE_BITS;
  localparam int CW = lstt_pkg::CNT_W;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A failed transaction reports no slot and no handle
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != lstt_pkg::RES_DONE) |->
      (out_tdata[SW-1:0] == '0) && (out_tdata[SW +: HB] == '0))
    else $error("failed transaction carries slot or handle");

  // Live count never exceeds the table depth
  a_live_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[SW+HB +: CW] <= CW'(lstt_pkg::SLOTS)))
    else $error("live count out of range");

  // One transaction at a time: input closes after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

endmodule

bind linear_slot_table_with_tombstones lstt_chk u_lstt_chk (.*);

// ===== sim/linear_slot_table_with_tombstones_test.sv =====
// Self-checking testbench for the slot table of keyed handles with tombstone deletion.
module linear_slot_table_with_tombstones_test;
  import lstt_pkg::*;

  // Any stretch this long without a transaction on either stream ends the run.
  // The slowest operation is a remove that triggers compaction.
  localparam int STALL_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 800;
  localparam int IDLE_PCT = 15;

  typedef struct {
    cmd_t                   cmd;
    logic [KEY_BITS-1:0]    key;
    logic [HANDLE_BITS-1:0] handle;
    logic [KEY_BITS-1:0]    new_key;
    logic [HANDLE_BITS-1:0] new_handle;
  } table_op_t;

  typedef struct {
    res_t                   status;
    logic [SLOT_W-1:0]      slot;
    logic [HANDLE_BITS-1:0] handle;
    logic [CNT_W-1:0]       live;
  } table_result_t;

  logic clk;
  logic rst_n;

  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  // in_tdata: key, handle, new_key, new_handle (from bit 0 up)
  logic [IN_DATA_W-1:0]    in_tdata = '0;
  // in_tuser: cmd
  logic [CMD_W-1:0]        in_tuser = CMD_STORE;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  // out_tdata: slot, found_handle, live_count, zero pad (from bit 0 up)
  logic [OUT_DATA_W-1:0]   out_tdata;
  // out_tuser: status
  logic [RES_W-1:0]        out_tuser;

  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [APB_AW-1:0]       paddr;
  logic [APB_DW-1:0]       pwdata;
  logic [APB_DW-1:0]       prdata;
  logic                    pready;

  // Shadow copy of the table, updated as each input transaction is accepted.
  logic [MARK_W-1:0]      mark_shadow[SLOTS];
  logic [KEY_BITS-1:0]    key_shadow[SLOTS];
  logic [HANDLE_BITS-1:0] handle_shadow[SLOTS];
  int                     live_shadow;
  int                     tomb_shadow;
  int                     tomb_limit;

  table_op_t     op_backlog[$];
  table_result_t predicted_results[$];
  int            ops_queued;
  int            ops_taken;
  int            errors;
  int            quiet_cycles;
  bit            in_taken;
  bit            no_idle;

  linear_slot_table_with_tombstones uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch on %s: got %0h, expected %0h", field, got, want);
    errors++;
  endtask

  // Apply one operation to the shadow table and return the result it must produce.
  task automatic apply_table_op(input table_op_t op, output table_result_t res);
    int i;
    int w;
    res.status = RES_NOT_FOUND;
    res.slot   = '0;
    res.handle = '0;
    case (op.cmd)
      CMD_STORE: begin
        // Full check comes first, so a reserved key on a full table reports full.
        if (live_shadow >= SLOTS) begin
          res.status = RES_FULL;
        end else if (op.key == '1) begin
          res.status = RES_RESERVED;
        end else begin
          for (i = 0; i < SLOTS; i++)
            if (mark_shadow[i] != MARK_LIVE) break;
          if (i < SLOTS) begin
            if (mark_shadow[i] == MARK_TOMB && tomb_shadow > 0) tomb_shadow--;
            mark_shadow[i]   = MARK_LIVE;
            key_shadow[i]    = op.key;
            handle_shadow[i] = op.handle;
            live_shadow++;
            res.status = RES_DONE;
            res.slot   = SLOT_W'(i);
          end else begin
            res.status = RES_FULL;
          end
        end
      end
      CMD_REMOVE: begin
        for (i = 0; i < SLOTS; i++) begin
          if (mark_shadow[i] == MARK_EMPTY) break;
          if (mark_shadow[i] == MARK_LIVE && key_shadow[i] == op.key) begin
            mark_shadow[i] = MARK_TOMB;
            if (live_shadow > 0) live_shadow--;
            tomb_shadow++;
            res.status = RES_DONE;
            res.slot   = SLOT_W'(i);
            // Compact: slide live entries to the front in order, clear the rest.
            if (tomb_shadow > tomb_limit) begin
              w = 0;
              for (int r = 0; r < SLOTS; r++) begin
                if (mark_shadow[r] == MARK_LIVE) begin
                  key_shadow[w]    = key_shadow[r];
                  handle_shadow[w] = handle_shadow[r];
                  mark_shadow[w]   = MARK_LIVE;
                  w++;
                end
              end
              for (int r = w; r < SLOTS; r++) mark_shadow[r] = MARK_EMPTY;
              tomb_shadow = 0;
            end
            break;
          end
        end
      end
      CMD_FIND: begin
        // Find walks the whole table; empties and tombstones are skipped.
        for (i = 0; i < SLOTS; i++) begin
          if (mark_shadow[i] == MARK_LIVE && (op.key == '0 || key_shadow[i] == op.key)) begin
            res.status = RES_DONE;
            res.slot   = SLOT_W'(i);
            res.handle = handle_shadow[i];
            break;
          end
        end
      end
      default: begin
        if (op.new_key == '1) begin
          res.status = RES_RESERVED;
        end else begin
          for (i = 0; i < SLOTS; i++) begin
            if (mark_shadow[i] == MARK_EMPTY) break;
            if (mark_shadow[i] == MARK_LIVE && handle_shadow[i] == op.handle) begin
              key_shadow[i]    = op.new_key;
              handle_shadow[i] = op.new_handle;
              res.status = RES_DONE;
              res.slot   = SLOT_W'(i);
              break;
            end
          end
        end
      end
    endcase
    res.live = CNT_W'(live_shadow);
  endtask

  // Driver: present queued operations, hold each until it is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // hold the pending transaction
    end else if (op_backlog.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
      table_op_t op;
      op = op_backlog.pop_front();
      in_tdata  <= {op.new_handle, op.new_key, op.handle, op.key};
      in_tuser  <= op.cmd;
      in_tvalid <= 1'b1;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Result side back-pressure.
  always @(negedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // Monitor: check results against the oldest prediction, then predict new ones.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (out_tvalid && out_tready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("unexpected result", out_tdata[31:0], '0);
        end else begin
          table_result_t want;
          want = predicted_results.pop_front();
          if (out_tuser != want.status)
            report_mismatch("status", 32'(out_tuser), 32'(want.status));
          if (out_tdata[SLOT_W-1:0] != want.slot)
            report_mismatch("slot", 32'(out_tdata[SLOT_W-1:0]), 32'(want.slot));
          if (out_tdata[SLOT_W +: HANDLE_BITS] != want.handle)
            report_mismatch("found_handle", 32'(out_tdata[SLOT_W +: HANDLE_BITS]),
                            32'(want.handle));
          if (out_tdata[SLOT_W+HANDLE_BITS +: CNT_W] != want.live)
            report_mismatch("live_count", 32'(out_tdata[SLOT_W+HANDLE_BITS +: CNT_W]),
                            32'(want.live));
        end
      end
      if (in_tvalid && in_tready) begin
        table_op_t op;
        table_result_t res;
        op.key        = in_tdata[0 +: KEY_BITS];
        op.handle     = in_tdata[KEY_BITS +: HANDLE_BITS];
        op.new_key    = in_tdata[KEY_BITS+HANDLE_BITS +: KEY_BITS];
        op.new_handle = in_tdata[2*KEY_BITS+HANDLE_BITS +: HANDLE_BITS];
        op.cmd        = cmd_t'(in_tuser);
        apply_table_op(op, res);
        predicted_results.push_back(res);
        ops_taken++;
      end
      if (psel && penable && pready && paddr[APB_AW-1:2] == REG_LIMIT) begin
        if (pwrite) tomb_limit = int'(pwdata[LIMIT_W-1:0]);
        else if (prdata != APB_DW'(tomb_limit)) report_mismatch("tombstone_limit", prdata, tomb_limit);
      end
    end
  end

  // Watchdog on transaction progress.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic queue_cmd(input cmd_t cmd, input logic [KEY_BITS-1:0] key,
                           input logic [HANDLE_BITS-1:0] handle,
                           input logic [KEY_BITS-1:0] new_key = '0,
                           input logic [HANDLE_BITS-1:0] new_handle = '0);
    table_op_t op;
    op.cmd = cmd;
    op.key = key;
    op.handle = handle;
    op.new_key = new_key;
    op.new_handle = new_handle;
    op_backlog.push_back(op);
    ops_queued++;
  endtask

  // Keys and handles mostly come from small pools so removes, finds and replaces hit.
  function automatic logic [KEY_BITS-1:0] pick_key(input int pool);
    int r;
    r = $urandom_range(99);
    if (r < 78) return KEY_BITS'($urandom_range(pool, 1));
    if (r < 83) return '0;
    if (r < 88) return '1;
    if (r < 91) return {{(KEY_BITS-1){1'b1}}, 1'b0};
    return KEY_BITS'($urandom());
  endfunction

  function automatic logic [HANDLE_BITS-1:0] pick_handle(input int pool);
    if ($urandom_range(99) < 80) return HANDLE_BITS'($urandom_range(pool, 0));
    return HANDLE_BITS'($urandom());
  endfunction

  task automatic queue_random_ops(input int count, input int pool);
    int pick;
    cmd_t cmd;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      cmd = (pick < 40) ? CMD_STORE : (pick < 65) ? CMD_REMOVE :
            (pick < 85) ? CMD_FIND : CMD_REPLACE;
      queue_cmd(cmd, pick_key(pool), pick_handle(pool), pick_key(pool), pick_handle(pool));
    end
  endtask

  // Pause the sender until every queued operation has produced its result.
  task automatic wait_drained();
    while (ops_taken != ops_queued || predicted_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apb_access(input logic write, input logic [APB_DW-1:0] data);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = write;
    paddr   = {REG_LIMIT, 2'b00};
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Write the tombstone limit and read it back.
  task automatic set_limit(input int value);
    apb_access(1'b1, APB_DW'(value));
    apb_access(1'b0, '0);
  endtask

  initial begin
    logic [KEY_BITS-1:0] live_keys[$];
    logic [KEY_BITS-1:0] swap;
    int j;
    int fill;

    for (int i = 0; i < SLOTS; i++) mark_shadow[i] = MARK_EMPTY;
    live_shadow = 0;
    tomb_shadow = 0;
    tomb_limit  = int'(LIMIT_RESET);
    ops_queued = 0;
    ops_taken  = 0;
    errors = 0;
    quiet_cycles = 0;
    no_idle = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_n = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // Reset value of the limit must read back.
    apb_access(1'b0, '0);

    // Directed: empty table, reserved key, duplicate keys, tombstone reuse.
    queue_cmd(CMD_FIND,    '0, '0);
    queue_cmd(CMD_REMOVE,  32'h1, '0);
    queue_cmd(CMD_REPLACE, '0, '0, 32'h5, 16'h5);
    queue_cmd(CMD_STORE,   '1, 16'h1);
    queue_cmd(CMD_STORE,   '0, '0);
    queue_cmd(CMD_STORE,   32'h1, '1);
    queue_cmd(CMD_STORE,   32'hFFFF_FFFE, 16'h8000);
    queue_cmd(CMD_STORE,   32'h1, 16'h1234);
    queue_cmd(CMD_FIND,    '0, '0);
    queue_cmd(CMD_FIND,    32'h1, '0);
    queue_cmd(CMD_FIND,    '1, '0);
    queue_cmd(CMD_REMOVE,  '1, '0);
    queue_cmd(CMD_REPLACE, '0, '1, '1, 16'h1);
    queue_cmd(CMD_REPLACE, '0, '1, 32'hAAAA_5555, 16'h5A5A);
    queue_cmd(CMD_REPLACE, '0, 16'h7777, 32'h7, 16'h7);
    queue_cmd(CMD_REMOVE,  32'h1, '0);
    queue_cmd(CMD_REMOVE,  '0, '0);
    queue_cmd(CMD_FIND,    '0, '0);
    queue_cmd(CMD_REPLACE, '0, '0, 32'h9, 16'h9);
    queue_cmd(CMD_STORE,   32'h0F0F_0F0F, 16'hF0F0);
    queue_cmd(CMD_REMOVE,  32'hAAAA_5555, '0);
    queue_cmd(CMD_FIND,    32'hFFFF_FFFE, '0);
    queue_cmd(CMD_STORE,   32'h5555_5555, 16'h00FF);
    wait_drained();

    queue_random_ops(250, 24);
    wait_drained();

    // Limit zero: every remove compacts. Pause the sender halfway through.
    set_limit(0);
    queue_random_ops(100, 20);
    wait_drained();
    queue_random_ops(100, 20);
    wait_drained();

    // Limit at 256: fill the table with no idling at all, then hit it when full.
    set_limit(256);
    no_idle = 1'b1;
    fill = SLOTS - live_shadow;
    for (int i = 0; i < fill; i++)
      queue_cmd(CMD_STORE, 32'h4000_0000 + KEY_BITS'(i), HANDLE_BITS'(i));
    queue_cmd(CMD_STORE,   32'h1, 16'h1);
    queue_cmd(CMD_STORE,   '1, 16'h1);
    queue_cmd(CMD_FIND,    32'h7FFF_FFFF, '0);
    queue_cmd(CMD_REMOVE,  32'h7FFF_FFFE, '0);
    queue_cmd(CMD_REPLACE, '0, 16'h0003, 32'h4000_1003, 16'h1003);
    queue_cmd(CMD_FIND,    '0, '0);
    wait_drained();
    no_idle = 1'b0;

    // Pile up tombstones in random order while the limit keeps them.
    for (int i = 0; i < SLOTS; i++)
      if (mark_shadow[i] == MARK_LIVE) live_keys.push_back(key_shadow[i]);
    for (int i = live_keys.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      swap = live_keys[i];
      live_keys[i] = live_keys[j];
      live_keys[j] = swap;
    end
    for (int i = 0; i < 150; i++) queue_cmd(CMD_REMOVE, live_keys[i], '0);
    wait_drained();

    // Drop the limit below the tombstone count: the next hit compacts a big table.
    set_limit(120);
    queue_cmd(CMD_REMOVE, live_keys[150], '0);
    queue_random_ops(200, 30);
    wait_drained();

    set_limit(7);
    queue_random_ops(200, 16);
    wait_drained();

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
